### sv/mabsg_pkg.sv
// shared types and constants for the multi-axis step generator
// no dependencies; imported by the top level, mabsg_front and mabsg_back
`default_nettype none

package mabsg_pkg;

  // fixed field widths
  localparam int unsigned TGT_W   = 24;
  localparam int unsigned DUR_W   = 24;
  localparam int unsigned KEY_W   = 8;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned NUM_TGT = 3;
  localparam int unsigned IDX_W   = 5;

  // action codes on the input channel
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_ENABLE = 2'd2;

  // classified command kinds
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_LOAD,
    CMD_ENABLE,
    CMD_NOP
  } cmd_kind_e;

  // one queued motion segment as held in a ring slot
  typedef struct packed {
    logic [NUM_TGT-1:0][TGT_W-1:0] target;
    logic [DUR_W-1:0]              duration;
    logic [KEY_W-1:0]              key;
    logic                          absolute;
  } slot_t;

  // command from front to back
  typedef struct packed {
    cmd_kind_e kind;
    slot_t     seg;
    logic      enable_value;
  } cmd_t;

  // result transaction
  typedef struct packed {
    logic                          accepted;
    logic [NUM_TGT-1:0]            step_mask;
    logic [NUM_TGT-1:0]            dir_mask;
    logic [NUM_TGT-1:0][TGT_W-1:0] position;
    logic [KEY_W-1:0]              active_key;
    logic [DUR_W-1:0]              ticks_left;
    logic [IDX_W-1:0]              read_index;
    logic [IDX_W-1:0]              write_index;
    logic                          drivers_on;
  } res_t;

endpackage

`default_nettype wire

### sv/multi_axis_bresenham_step_generator.sv
// top level of the multi-axis step generator
// depends on mabsg_pkg, mabsg_front, mabsg_back and mabsg_ram
`default_nettype none

// Three-axis Bresenham step generator with a ring of SLOTS queued motion
// segments. Each input transaction (tick, segment load or driver enable)
// produces exactly one result transaction carrying the status after it.
// The block sustains one transaction per clock while the output is not
// stalled: the front end decodes the action into a two-entry command queue
// and the back end executes one command per cycle; a command waits in a queue
// entry, its result in the state registers. The ring sits in a registered-read
// memory that is always read one slot ahead of the read head, which lets a
// segment be taken on any tick without waiting for the memory. One ring slot
// always stays empty, so SLOTS-1 segments can wait. No clearing pass after reset.

module multi_axis_bresenham_step_generator #(
  parameter int unsigned SLOTS         = 32,
  parameter int unsigned AXES          = 3,
  parameter int unsigned FRACTION_BITS = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [23:0] target_a_i,
  input  wire logic signed [23:0] target_b_i,
  input  wire logic signed [23:0] target_c_i,
  input  wire logic [23:0]        duration_i,
  input  wire logic [7:0]         key_i,
  input  wire logic               absolute_i,
  input  wire logic               enable_value_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic               accepted_o,
  output      logic [2:0]         step_mask_o,
  output      logic [2:0]         dir_mask_o,
  output      logic signed [23:0] position_a_o,
  output      logic signed [23:0] position_b_o,
  output      logic signed [23:0] position_c_o,
  output      logic [7:0]         active_key_o,
  output      logic [23:0]        ticks_left_o,
  output      logic [4:0]         read_index_o,
  output      logic [4:0]         write_index_o,
  output      logic               drivers_on_o
);

  import mabsg_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  // decode and queue
  mabsg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .target_a_i     (target_a_i),
    .target_b_i     (target_b_i),
    .target_c_i     (target_c_i),
    .duration_i     (duration_i),
    .key_i          (key_i),
    .absolute_i     (absolute_i),
    .enable_value_i (enable_value_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  // execute
  mabsg_back #(
    .SLOTS         (SLOTS),
    .AXES          (AXES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  // result fields
  assign accepted_o    = res.accepted;
  assign step_mask_o   = res.step_mask;
  assign dir_mask_o    = res.dir_mask;
  assign position_a_o  = res.position[0];
  assign position_b_o  = res.position[1];
  assign position_c_o  = res.position[2];
  assign active_key_o  = res.active_key;
  assign ticks_left_o  = res.ticks_left;
  assign read_index_o  = res.read_index;
  assign write_index_o = res.write_index;
  assign drivers_on_o  = res.drivers_on;

endmodule

`default_nettype wire

### sv/mabsg_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; read during write to the same address returns old data
`default_nettype none

module mabsg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### sv/mabsg_front.sv
// front end: accepts input transactions, classifies the action, queues commands
// depends on mabsg_pkg; feeds mabsg_back through a two-entry queue
`default_nettype none

module mabsg_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [23:0] target_a_i,
  input  wire logic signed [23:0] target_b_i,
  input  wire logic signed [23:0] target_c_i,
  input  wire logic [23:0]        duration_i,
  input  wire logic [7:0]         key_i,
  input  wire logic               absolute_i,
  input  wire logic               enable_value_i,
  output      logic               cmd_valid_o,
  input  wire logic               cmd_ready_i,
  output      mabsg_pkg::cmd_t    cmd_o
);

  import mabsg_pkg::*;

  cmd_t       cmd_new;
  cmd_t       entry_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  // action decode
  always_comb begin
    cmd_new.seg.target[0]  = target_a_i;
    cmd_new.seg.target[1]  = target_b_i;
    cmd_new.seg.target[2]  = target_c_i;
    cmd_new.seg.duration   = duration_i;
    cmd_new.seg.key        = key_i;
    cmd_new.seg.absolute   = absolute_i;
    cmd_new.enable_value   = enable_value_i;
    unique case (action_i)
      ACT_TICK:   cmd_new.kind = CMD_TICK;
      ACT_LOAD:   cmd_new.kind = CMD_LOAD;
      ACT_ENABLE: cmd_new.kind = CMD_ENABLE;
      default:    cmd_new.kind = CMD_NOP;
    endcase
  end

  // queue handshake
  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wp_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

### sv/mabsg_back.sv
// back end: segment ring, tick timer and per-axis bresenham accumulators
// depends on mabsg_pkg and mabsg_ram; takes commands from mabsg_front
`default_nettype none

module mabsg_back #(
  parameter int unsigned SLOTS         = 32,
  parameter int unsigned AXES          = 3,
  parameter int unsigned FRACTION_BITS = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  output      logic            cmd_ready_o,
  input  wire mabsg_pkg::cmd_t cmd_i,
  output      logic            res_valid_o,
  input  wire logic            res_ready_i,
  output      mabsg_pkg::res_t res_o
);

  import mabsg_pkg::*;

  localparam int unsigned IW  = $clog2(SLOTS);
  localparam int unsigned NAX = (AXES < NUM_TGT) ? AXES : NUM_TGT;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
    return (idx == LAST) ? '0 : idx + 1'b1;
  endfunction

  logic                fire, is_tick, is_load, is_en;
  logic                running, ring_full, take;
  logic [IW-1:0]       hr_q, hr_d, hw_q, hw_d, w_idx, ram_raddr;
  logic                ram_we;
  slot_t               ram_rdata, byp_data_q, slot;
  logic                byp_q;
  logic [DUR_W-1:0]    rem_q, rem_d, full_q, full_d;
  logic [DUR_W-2:0]    half_q, half_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic                en_q, en_d;
  logic                acc_q, acc_d;
  logic                out_valid_q, out_valid_d;
  logic [NUM_TGT-1:0]  mask_q;
  logic [NAX-1:0]      stp_ax, dir_ax;
  logic [NAX-1:0][TGT_W-1:0] pos_ax;
  logic [NUM_TGT-1:0]  stp_vec, dir_vec;
  logic [NUM_TGT-1:0][TGT_W-1:0] pos_vec;
  logic [IW+IDX_W-1:0] hr_ext, hw_ext;

  // command decode
  assign cmd_ready_o = !out_valid_q || res_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign is_tick     = fire && (cmd_i.kind == CMD_TICK);
  assign is_load     = fire && (cmd_i.kind == CMD_LOAD);
  assign is_en       = fire && (cmd_i.kind == CMD_ENABLE);

  // ring status and segment hand-over
  assign running   = (rem_q != '0);
  assign w_idx     = next_slot(hw_q);
  assign ring_full = (w_idx == hr_q);
  assign take      = is_tick && (rem_q[DUR_W-1:1] == '0) && (hr_q != hw_q);

  // ring memory, read one slot ahead of the read head
  mabsg_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (w_idx),
    .wdata_i (cmd_i.seg),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot = byp_q ? byp_data_q : ram_rdata;

  // shared control state update
  always_comb begin
    hr_d   = hr_q;
    hw_d   = hw_q;
    rem_d  = rem_q;
    half_d = half_q;
    full_d = full_q;
    key_d  = key_q;
    en_d   = en_q;
    ram_we = 1'b0;
    acc_d  = 1'b1;
    if (is_tick) begin
      if (running) begin
        rem_d = rem_q - 1'b1;
      end
      if (take) begin
        hr_d   = next_slot(hr_q);
        key_d  = slot.key;
        half_d = slot.duration[DUR_W-1:1];
        full_d = slot.duration;
        rem_d  = slot.duration;
        en_d   = 1'b1;
      end
    end
    if (is_load) begin
      if (ring_full) begin
        acc_d = 1'b0;
      end else begin
        ram_we = 1'b1;
        hw_d   = w_idx;
      end
    end
    if (is_en) begin
      en_d = cmd_i.enable_value;
    end
    ram_raddr = next_slot(hr_d);
  end

  assign out_valid_d = fire ? 1'b1 : (res_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hr_q        <= '0;
      hw_q        <= '0;
      rem_q       <= '0;
      half_q      <= '0;
      full_q      <= '0;
      key_q       <= '0;
      en_q        <= 1'b0;
      acc_q       <= 1'b1;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      hr_q        <= hr_d;
      hw_q        <= hw_d;
      rem_q       <= rem_d;
      half_q      <= half_d;
      full_q      <= full_d;
      key_q       <= key_d;
      en_q        <= en_d;
      out_valid_q <= out_valid_d;
      byp_q       <= ram_we && (w_idx == ram_raddr);
      if (fire) begin
        acc_q  <= acc_d;
        mask_q <= stp_vec;
      end
    end
  end

  // write-to-read forwarding for the slot just written
  always_ff @(posedge clk_i) begin
    byp_data_q <= cmd_i.seg;
  end

  // per-axis accumulator, position and direction
  for (genvar a = 0; a < NAX; a++) begin : g_axis
    logic [POS_W-1:0] steps_q, steps_d, accum_q, accum_d, pos_q, pos_d;
    logic             dir_q, dir_d;
    logic [POS_W-1:0] tgt, sum, sub, rel, neg;
    logic             stp, fwd;

    assign tgt = {{(POS_W-TGT_W){slot.target[a][TGT_W-1]}}, slot.target[a]} << FRACTION_BITS;
    assign sum = accum_q + steps_q;
    assign sub = accum_q + steps_q - {{(POS_W-DUR_W){1'b0}}, full_q};
    assign stp = running && ($signed(sum) > $signed({{(POS_W-DUR_W+1){1'b0}}, half_q}));

    // relative move and its negation against the position after this tick
    always_comb begin
      if (!slot.absolute) begin
        rel = tgt;
        neg = '0 - tgt;
      end else if (!stp) begin
        rel = tgt - pos_q;
        neg = pos_q - tgt;
      end else if (dir_q) begin
        rel = tgt + ~pos_q;
        neg = pos_q + ~tgt + POS_W'(2);
      end else begin
        rel = tgt + ~pos_q + POS_W'(2);
        neg = pos_q + ~tgt;
      end
    end

    assign fwd = !rel[POS_W-1] && (rel != '0);

    always_comb begin
      steps_d = steps_q;
      accum_d = accum_q;
      pos_d   = pos_q;
      dir_d   = dir_q;
      if (is_tick && running) begin
        if (stp) begin
          accum_d = sub;
          pos_d   = dir_q ? pos_q + 1'b1 : pos_q - 1'b1;
        end else begin
          accum_d = sum;
        end
      end
      if (take) begin
        steps_d = fwd ? rel : neg;
        accum_d = '0;
        dir_d   = fwd;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        steps_q <= '0;
        accum_q <= '0;
        pos_q   <= '0;
        dir_q   <= 1'b0;
      end else begin
        steps_q <= steps_d;
        accum_q <= accum_d;
        pos_q   <= pos_d;
        dir_q   <= dir_d;
      end
    end

    assign stp_ax[a] = is_tick && stp;
    assign dir_ax[a] = dir_q;
    assign pos_ax[a] = pos_q[FRACTION_BITS+TGT_W-1:FRACTION_BITS];
  end

  // axes without a datapath report zero
  for (genvar i = 0; i < NUM_TGT; i++) begin : g_out
    if (i < NAX) begin : g_used
      assign stp_vec[i] = stp_ax[i];
      assign dir_vec[i] = dir_ax[i];
      assign pos_vec[i] = pos_ax[i];
    end else begin : g_unused
      assign stp_vec[i] = 1'b0;
      assign dir_vec[i] = 1'b0;
      assign pos_vec[i] = '0;
    end
  end

  // result transaction, held in the state registers
  assign hr_ext = {{IDX_W{1'b0}}, hr_q};
  assign hw_ext = {{IDX_W{1'b0}}, hw_q};

  assign res_valid_o       = out_valid_q;
  assign res_o.accepted    = acc_q;
  assign res_o.step_mask   = mask_q;
  assign res_o.dir_mask    = dir_vec;
  assign res_o.position    = pos_vec;
  assign res_o.active_key  = key_q;
  assign res_o.ticks_left  = rem_q;
  assign res_o.read_index  = hr_ext[IDX_W-1:0];
  assign res_o.write_index = hw_ext[IDX_W-1:0];
  assign res_o.drivers_on  = en_q;

endmodule

`default_nettype wire
